// ----- hdl/slk_pkg.sv -----
package slk_pkg;

	localparam int CAPACITY  = 64;
	localparam int KEY_BYTES = 8;

	localparam int KEY_W   = 64;
	localparam int SCORE_W = 14;
	localparam int TOTAL_W = 20;
	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);

	localparam int POS_OUT_W = 6;
	localparam int CNT_OUT_W = 7;

	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);
	localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(10000);

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_DELETED   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_BAD_SCORE = 3'd5;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
		logic               gender;
	} rec_t;

	// Per-cycle commands broadcast to every cell of the row.
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

// ----- hdl/slk_cell.sv -----
module slk_cell
	import slk_pkg::*;
(
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [KEY_W-1:0] req_key,
	input  rec_t             new_rec,
	input  logic             occupied,
	input  logic             ge_prev,
	input  rec_t             left_rec,
	input  rec_t             right_rec,
	output rec_t             rec,
	output logic             ge,
	output logic             eq
);

	rec_t rec_q;
	logic ge_q;
	logic eq_q;

	// An empty cell counts as holding a key above every other, so the
	// greater-or-equal flags always form a step along the row.
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			ge_q <= occupied ? (rec_q.key >= req_key) : 1'b1;
			eq_q <= occupied && (rec_q.key == req_key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (ge_prev) begin
				rec_q <= left_rec;
			end else if (ge_q) begin
				rec_q <= new_rec;
			end
		end else if (ctl.del) begin
			if (ge_q) begin
				rec_q <= right_rec;
			end
		end
	end

	assign rec = rec_q;
	assign ge  = ge_q;
	assign eq  = eq_q;

endmodule

// ----- hdl/sorted_key_list_insert_delete_core.sv -----
// Sorted key list with insert and delete by key.
//
// Requests arrive as beats on the s_ channel: s_tuser carries the request
// kind (insert or delete) and s_tdata the key, gender and score. Each
// request yields exactly one result beat on the m_ channel, with the outcome
// code in m_tuser and position, count, score total, removed payload and the
// first and last stored keys in m_tdata.
//
// Records sit in a row of identical cells, one record per cell, in ascending
// key order. A request passes through these phases when the output is free: the
// accepting phase, a phase in which every cell compares its key with the
// request key, a phase in which the step in those flags gives the position
// and every cell at or beyond it shifts by one place, and a phase that loads
// the output register. s_tready is high only while no request is in progress,
// so a new request is taken only once the last one has loaded its result.
//
// If the receiver stalls, the result waits in the output register; the next
// request is accepted and then waits in its final step until that is taken.
// Reset empties the list; cell contents are left undefined.
module sorted_key_list_insert_delete_core
	import slk_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [63:0] key, [64] gender, [78:65] score, [79] zero
	input  logic [79:0]  s_tdata,
	// [0] req_type
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [5:0] position, [12:6] entry_count, [32:13] score_total,
	// [46:33] removed_score, [47] removed_gender, [111:48] first_key,
	// [175:112] last_key
	output logic [175:0] m_tdata,
	// [2:0] status
	output logic [2:0]   m_tuser
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_DEC  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	// Request held for the duration of its work.
	logic req_type_q;
	rec_t req_q;

	logic [CNT_W-1:0]   count_q;
	logic [TOTAL_W-1:0] total_q;

	// Outcome of the decision step, waiting for the final step.
	logic [2:0]         status_q;
	logic [IDX_W-1:0]   pos_q;
	logic [SCORE_W-1:0] rem_score_q;
	logic               rem_gender_q;

	logic         m_tvalid_q;
	logic [175:0] m_tdata_q;
	logic [2:0]   m_tuser_q;

	rec_t          cell_rec [CAPACITY];
	logic [CAPACITY-1:0] ge;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] step;
	logic [CAPACITY-1:0] last_sel;
	cell_ctl_t     ctl;

	logic s_acc;
	logic out_free;

	logic               hit;
	logic [IDX_W-1:0]   idx;
	logic [SCORE_W-1:0] hit_score;
	logic               hit_gender;
	logic [2:0]         dec_status;
	logic               dec_ins;
	logic               dec_del;

	logic [KEY_W-1:0] first_key;
	logic [KEY_W-1:0] last_key;

	logic [IDX_W+POS_OUT_W-1:0] pos_ext;
	logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Occupancy, the step in the compare flags and the last occupied cell
	// all follow from constant-index tests on each cell.
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_row
			assign occ[gi] = (count_q > CNT_W'(gi));
			if (gi == 0) begin : g_head
				assign step[gi] = ge[gi];
			end else begin : g_body
				assign step[gi] = ge[gi] && !ge[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_tail
				assign last_sel[gi] = occ[gi];
			end else begin : g_mid
				assign last_sel[gi] = occ[gi] && !occ[gi+1];
			end

			slk_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.req_key   (req_q.key),
				.new_rec   (req_q),
				.occupied  (occ[gi]),
				.ge_prev   ((gi == 0) ? 1'b0 : ge[(gi == 0) ? 0 : gi-1]),
				.left_rec  (cell_rec[(gi == 0) ? 0 : gi-1]),
				.right_rec (cell_rec[(gi == CAPACITY - 1) ? gi : gi+1]),
				.rec       (cell_rec[gi]),
				.ge        (ge[gi]),
				.eq        (eq[gi])
			);
		end
	endgenerate

	// The step marks at most one cell (exactly one while the list has room): its
	// index is the position, and the record there is the one a delete removes.
	always_comb begin
		idx        = '0;
		hit        = 1'b0;
		hit_score  = '0;
		hit_gender = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (step[i]) begin
				idx        = idx | IDX_W'(i);
				hit        = hit | eq[i];
				hit_score  = hit_score | cell_rec[i].score;
				hit_gender = hit_gender | cell_rec[i].gender;
			end
		end
	end

	always_comb begin
		dec_ins    = 1'b0;
		dec_del    = 1'b0;
		dec_status = ST_NOT_FOUND;
		if (req_type_q == REQ_INSERT) begin
			priority if (hit) begin
				dec_status = ST_DUPLICATE;
			end else if (req_q.score > SCORE_MAX) begin
				dec_status = ST_BAD_SCORE;
			end else if (count_q >= CNT_W'(CAPACITY)) begin
				dec_status = ST_FULL;
			end else begin
				dec_status = ST_INSERTED;
				dec_ins    = 1'b1;
			end
		end else begin
			if (hit) begin
				dec_status = ST_DELETED;
				dec_del    = 1'b1;
			end
		end
	end

	always_comb begin
		ctl.cmp = (state_q == S_CMP);
		ctl.ins = (state_q == S_DEC) && dec_ins;
		ctl.del = (state_q == S_DEC) && dec_del;
	end

	always_comb begin
		first_key = occ[0] ? cell_rec[0].key : '0;
		last_key  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (last_sel[i]) begin
				last_key = last_key | cell_rec[i].key;
			end
		end
	end

	assign pos_ext = {{POS_OUT_W{1'b0}}, pos_q};
	assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					state_q <= S_FIN;
					if (dec_ins) begin
						count_q <= count_q + CNT_W'(1);
						total_q <= total_q + TOTAL_W'(req_q.score);
					end else if (dec_del) begin
						count_q <= count_q - CNT_W'(1);
						total_q <= total_q - TOTAL_W'(hit_score);
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			req_type_q   <= s_tuser[0];
			req_q.key    <= s_tdata[63:0] & KEY_MASK;
			req_q.gender <= s_tdata[64];
			req_q.score  <= s_tdata[78:65];
		end
		if (state_q == S_DEC) begin
			status_q     <= dec_status;
			pos_q        <= (dec_status == ST_INSERTED || dec_status == ST_DUPLICATE ||
			                 dec_status == ST_DELETED) ? idx : '0;
			rem_score_q  <= dec_del ? hit_score : '0;
			rem_gender_q <= dec_del ? hit_gender : 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			m_tuser_q          <= status_q;
			m_tdata_q[5:0]     <= pos_ext[POS_OUT_W-1:0];
			m_tdata_q[12:6]    <= cnt_ext[CNT_OUT_W-1:0];
			m_tdata_q[32:13]   <= total_q;
			m_tdata_q[46:33]   <= rem_score_q;
			m_tdata_q[47]      <= rem_gender_q;
			m_tdata_q[111:48]  <= first_key;
			m_tdata_q[175:112] <= last_key;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The list never holds more records than there are cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("record count above capacity");

	// With room left, the compare flags step from low to high exactly once.
	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEC) && (count_q < CNT_W'(CAPACITY)) |-> $onehot(step))
		else $error("compare flags do not form a single step");

	// Count and total change only in the decision step.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DEC) |=> $stable(count_q) && $stable(total_q))
		else $error("count or total changed outside the decision step");

endmodule
